// ===== rtl/aiw_pkg.sv =====
// Package for the affine inverse warp unit: datapath widths, register
// indexes, controller states and the controller-to-datapath command struct.
// No dependencies.
package aiw_pkg;

   // Fixed field and arithmetic widths
   localparam int COEF_W  = 32;           // Q16.16 coefficient
   localparam int FRAC_W  = 16;           // fraction bits of Q16.16
   localparam int POS_W   = 8;            // pos_x / pos_y
   localparam int PIX_W   = 24;           // pixel color
   localparam int DIM_W   = 9;            // image_width / image_height
   localparam int PROD_W  = COEF_W + POS_W + 1;   // signed coef * unsigned pos
   localparam int ACC_W   = PROD_W + 2;           // sum of three terms
   localparam int Q_W     = ACC_W - FRAC_W;       // integer part of the sum
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_BY_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_BY_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_BY_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_BY_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd7;

   // Register reset values
   localparam logic [COEF_W-1:0] COEF_ONE  = 32'h0001_0000;
   localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;
   localparam logic [DIM_W-1:0]  DIM_RESET = 9'd256;

   // Item codes
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_FETCH = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_CHK,
      ST_RD,
      ST_RSP
   } state_type;

   // Controller commands to the datapath
   typedef struct packed {
      logic load;      // write the request pixel into the frame store
      logic capture;   // latch the fetch coordinates
      logic mul_en;    // register the coefficient products
      logic sum_en;    // register the two mapping sums
      logic chk_en;    // truncate, bounds check, register source coordinate
      logic rd_en;     // read the frame store
   } dp_cmd_type;

endpackage

// ===== rtl/aiw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module aiw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/aiw_ctrl.sv =====
// Controller for the affine inverse warp unit: sequences one fetch through
// multiply, sum, check, read and response steps. Uses aiw_pkg.
module aiw_ctrl import aiw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_action,
   output logic       busy,
   output logic       rsp_strobe,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACTION_FETCH)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_CHK;
         ST_CHK:  state_in = ST_RD;
         ST_RD:   state_in = ST_RSP;
         ST_RSP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.load    = accept && (req_action == ACTION_LOAD);
            cmd.capture = accept && (req_action == ACTION_FETCH);
         end
         ST_MUL:  cmd.mul_en = 1'b1;
         ST_SUM:  cmd.sum_en = 1'b1;
         ST_CHK:  cmd.chk_en = 1'b1;
         ST_RD:   cmd.rd_en  = 1'b1;
         ST_RSP:  rsp_strobe = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

// ===== rtl/aiw_datapath.sv =====
// Datapath for the affine inverse warp unit: configuration registers,
// coordinate mapping arithmetic, bounds check and frame store.
// Uses aiw_pkg and aiw_ram.
module aiw_datapath import aiw_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [PIX_W-1:0]     req_pixel_in,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data,
   output logic [PIX_W-1:0]     rsp_pixel_out,
   output logic                 rsp_inside_res
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SX_W   = $clog2(MAX_WIDTH);
   localparam int SY_W   = $clog2(MAX_HEIGHT);
   localparam logic signed [Q_W-1:0] MAX_W_Q = Q_W'(MAX_WIDTH);
   localparam logic signed [Q_W-1:0] MAX_H_Q = Q_W'(MAX_HEIGHT);

   // configuration registers
   logic signed [COEF_W-1:0] cx0_ff, cxx_ff, cxy_ff, cy0_ff, cyx_ff, cyy_ff;
   logic [DIM_W-1:0]         width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx0_ff    <= COEF_ZERO;
         cxx_ff    <= COEF_ONE;
         cxy_ff    <= COEF_ZERO;
         cy0_ff    <= COEF_ZERO;
         cyx_ff    <= COEF_ZERO;
         cyy_ff    <= COEF_ONE;
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COEF_X_OFFSET: cx0_ff    <= csr_data;
            CSR_COEF_X_BY_X:   cxx_ff    <= csr_data;
            CSR_COEF_X_BY_Y:   cxy_ff    <= csr_data;
            CSR_COEF_Y_OFFSET: cy0_ff    <= csr_data;
            CSR_COEF_Y_BY_X:   cyx_ff    <= csr_data;
            CSR_COEF_Y_BY_Y:   cyy_ff    <= csr_data;
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data[DIM_W-1:0];
            default:           width_ff  <= width_ff;
         endcase
      end
   end

   // fetch coordinates
   logic [POS_W-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
      end
   end

   // products: signed coefficient times zero-extended coordinate
   logic signed [PROD_W-1:0] xs, ys;
   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;

   assign xs = PROD_W'($signed({1'b0, x_ff}));
   assign ys = PROD_W'($signed({1'b0, y_ff}));

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         pxx_ff <= PROD_W'(cxx_ff) * xs;
         pxy_ff <= PROD_W'(cxy_ff) * ys;
         pyx_ff <= PROD_W'(cyx_ff) * xs;
         pyy_ff <= PROD_W'(cyy_ff) * ys;
      end
   end

   // mapping sums in Q27.16
   logic signed [ACC_W-1:0] accx_ff, accy_ff;

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         accx_ff <= ACC_W'(cx0_ff) + ACC_W'(pxx_ff) + ACC_W'(pxy_ff);
         accy_ff <= ACC_W'(cy0_ff) + ACC_W'(pyx_ff) + ACC_W'(pyy_ff);
      end
   end

   // truncate toward zero: floor, plus one for a negative sum with a fraction
   logic signed [Q_W-1:0] qx, qy;
   logic                  rnd_x, rnd_y;
   logic                  in_x, in_y;

   assign rnd_x = accx_ff[ACC_W-1] && (accx_ff[FRAC_W-1:0] != '0);
   assign rnd_y = accy_ff[ACC_W-1] && (accy_ff[FRAC_W-1:0] != '0);
   assign qx = $signed(accx_ff[ACC_W-1:FRAC_W]) + $signed(Q_W'({1'b0, rnd_x}));
   assign qy = $signed(accy_ff[ACC_W-1:FRAC_W]) + $signed(Q_W'({1'b0, rnd_y}));

   // inside when 0 <= q < min(size register, store size)
   assign in_x = !qx[Q_W-1] && (qx < $signed(Q_W'(width_ff))) && (qx < MAX_W_Q);
   assign in_y = !qy[Q_W-1] && (qy < $signed(Q_W'(height_ff))) && (qy < MAX_H_Q);

   logic [SX_W-1:0] sx_ff;
   logic [SY_W-1:0] sy_ff;
   logic            inside_ff;

   always_ff @(posedge clock) begin
      if (cmd.chk_en) begin
         sx_ff     <= qx[SX_W-1:0];
         sy_ff     <= qy[SY_W-1:0];
         inside_ff <= in_x && in_y;
      end
   end

   // frame store addressing, row-major
   logic              load_ok;
   logic              load_we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [PIX_W-1:0]  rdata;

   assign load_ok = (32'(req_pos_x) < 32'(MAX_WIDTH)) && (32'(req_pos_y) < 32'(MAX_HEIGHT));
   assign load_we = cmd.load && load_ok;
   assign waddr   = ADDR_W'(req_pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_pos_x);
   assign raddr   = ADDR_W'(sy_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_ff);

   aiw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (load_we),
      .waddr (waddr),
      .wdata (req_pixel_in),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (rdata)
   );

   // result: stored pixel when inside, zero otherwise
   assign rsp_pixel_out  = inside_ff ? rdata : '0;
   assign rsp_inside_res = inside_ff;

endmodule

// ===== rtl/affine_inverse_warp_unit.sv =====
// Affine inverse warp unit: loads pixels into a frame store, fetches warped pixels.
// Load: written into the frame store at the transfer edge; busy stays low.
// Fetch: runs the multiply/sum/check/read/response controller sequence and strobes
// the result in the response state; busy stays high until the sequence ends.
// Synchronous active-high reset restores the coefficient and size registers;
// frame store contents are undefined until written. The receiver cannot stall.
module affine_inverse_warp_unit import aiw_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [PIX_W-1:0]     req_pixel_in,
   // response
   output logic                 rsp_strobe,
   output logic [PIX_W-1:0]     rsp_pixel_out,
   output logic                 rsp_inside_res,
   // configuration
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   dp_cmd_type cmd;

   aiw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   aiw_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pixel_in   (req_pixel_in),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule
